[src/ip4ap_pkg.sv]
package ip4ap_pkg;

    localparam int unsigned PhaseWidth = 3;

    localparam logic [PhaseWidth-1:0] PH_LEAD  = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_OCTET = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_DOT   = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_PORT  = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_DONE  = 3'd4;
    localparam logic [PhaseWidth-1:0] PH_FAIL  = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [8:0] OctetLimit = 9'd256;

    localparam logic REG_DEFAULT_PORT = 1'b0;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
        logic [15:0] port;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[src/ipv4_dotted_address_port_parser_unit.sv]
// A result is registered when the terminating NUL is accepted: into the output register, or
// into the skid entry while the output is held. One character is taken per cycle while o_stall
// is low; the parse state update (octet and port multiply-by-ten plus compares) is combinational,
// so characters stream back to back. Results pass through an output register backed by a one-entry
// skid buffer. Reset (synchronous, active low): parser back to leading-whitespace phase, default
// port 0, output and skid registers empty.
module ipv4_dotted_address_port_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [31:0] o_address,
    output logic [15:0] o_port,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_default_port;

    logic [ip4ap_pkg::PhaseWidth-1:0] r_phase, n_phase;
    logic [8:0]  r_octet, n_octet;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_port, n_port;
    logic        r_port_given, n_port_given;

    ip4ap_pkg::t_result r_out, r_skid, new_result;
    logic r_out_valid, r_skid_valid;

    logic        accept;
    logic        out_fire;
    logic        emit;
    logic [3:0]  digit;
    logic [12:0] octet_mac;
    logic [19:0] port_mac;
    logic [31:0] addr_merged;
    logic        c_space, c_digit;

    assign pready  = 1'b1;
    assign prdata  = (paddr == ip4ap_pkg::REG_DEFAULT_PORT) ? {16'h0, r_default_port} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_port <= 16'h0;
        end else if (psel && penable && pwrite && paddr == ip4ap_pkg::REG_DEFAULT_PORT) begin
            r_default_port <= pwdata[15:0];
        end
    end

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    assign c_space = ip4ap_pkg::is_space(i_ch);
    assign c_digit = ip4ap_pkg::is_digit(i_ch);
    assign digit   = 4'(i_ch - ip4ap_pkg::CH_ZERO);

    assign octet_mac   = 13'(r_octet) * 13'd10 + 13'(digit);
    assign port_mac    = 20'(r_port) * 20'd10 + 20'(digit);
    assign addr_merged = r_addr | ({r_octet[7:0], 24'h0} >> {r_idx, 3'b000});

    always_comb begin
        n_phase      = r_phase;
        n_octet      = r_octet;
        n_idx        = r_idx;
        n_addr       = r_addr;
        n_port       = r_port;
        n_port_given = r_port_given;
        unique case (r_phase)
            ip4ap_pkg::PH_LEAD, ip4ap_pkg::PH_DOT: begin
                if (!(r_phase == ip4ap_pkg::PH_LEAD && c_space)) begin
                    if (c_digit) begin
                        n_octet = 9'(digit);
                        n_phase = ip4ap_pkg::PH_OCTET;
                    end else begin
                        n_phase = ip4ap_pkg::PH_FAIL;
                    end
                end
            end
            ip4ap_pkg::PH_OCTET: begin
                if (c_digit) begin
                    n_octet = (octet_mac > 13'(ip4ap_pkg::OctetLimit))
                            ? ip4ap_pkg::OctetLimit : octet_mac[8:0];
                end else if (r_octet >= ip4ap_pkg::OctetLimit) begin
                    n_phase = ip4ap_pkg::PH_FAIL;
                end else begin
                    n_addr = addr_merged;
                    priority if (i_ch == ip4ap_pkg::CH_NUL || c_space) begin
                        n_phase = ip4ap_pkg::PH_DONE;
                    end else if (i_ch == ip4ap_pkg::CH_COLON) begin
                        n_port_given = 1'b1;
                        n_port       = 16'h0;
                        n_phase      = ip4ap_pkg::PH_PORT;
                    end else if (i_ch == ip4ap_pkg::CH_DOT && r_idx != 2'd3) begin
                        n_idx   = r_idx + 2'd1;
                        n_phase = ip4ap_pkg::PH_DOT;
                    end else begin
                        n_phase = ip4ap_pkg::PH_FAIL;
                    end
                end
            end
            ip4ap_pkg::PH_PORT: begin
                if (c_digit) begin
                    n_port = port_mac[15:0];
                end else begin
                    n_phase = ip4ap_pkg::PH_DONE;
                end
            end
            ip4ap_pkg::PH_DONE: begin
            end
            default: begin
                n_phase = ip4ap_pkg::PH_FAIL;
            end
        endcase
    end

    assign emit = accept && (i_ch == ip4ap_pkg::CH_NUL);

    always_comb begin
        if (n_phase == ip4ap_pkg::PH_DONE) begin
            new_result.ok      = 1'b1;
            new_result.address = n_addr;
            new_result.port    = n_port_given ? n_port : r_default_port;
        end else begin
            new_result.ok      = 1'b0;
            new_result.address = 32'h0;
            new_result.port    = 16'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ip4ap_pkg::PH_LEAD;
            r_octet      <= 9'h0;
            r_idx        <= 2'd0;
            r_addr       <= 32'h0;
            r_port       <= 16'h0;
            r_port_given <= 1'b0;
        end else if (emit) begin
            r_phase      <= ip4ap_pkg::PH_LEAD;
            r_octet      <= 9'h0;
            r_idx        <= 2'd0;
            r_addr       <= 32'h0;
            r_port       <= 16'h0;
            r_port_given <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_octet      <= n_octet;
            r_idx        <= n_idx;
            r_addr       <= n_addr;
            r_port       <= n_port;
            r_port_given <= n_port_given;
        end
    end

    // output register with skid entry; stall only while the skid holds a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (emit) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (emit) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= new_result;
            end else begin
                r_out <= new_result;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_ok      = r_out.ok;
    assign o_address = r_out.address;
    assign o_port    = r_out.port;

endmodule
